// ===== rtl/tdm_pkg.sv =====
`default_nettype none

package tdm_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] CfgTickRateHz      = 2'd0;
	localparam logic [1:0] CfgReportPeriod    = 2'd1;

	localparam int unsigned CfgIndexWidth = 2;
	localparam int unsigned CfgDataWidth  = 20;

	localparam logic [19:0] TickRateReset      = 20'd200;
	localparam logic [15:0] ReportPeriodReset  = 16'd2000;

	localparam logic [63:0] NsPerMs = 64'd1000000;
	localparam logic [63:0] NsPerUs = 64'd1000;

	// ceil(2^71 / 1000): x / 1000 = ((x >> 3) * RecipUs) >> 68 for every 64-bit x
	localparam logic [63:0] RecipUs = 64'd2361183241434822607;
	// ceil(2^77 / 15625): x / 1000000 = ((x >> 6) * RecipMs) >> 77 for every 64-bit x
	localparam logic [63:0] RecipMs = 64'd9671406556917033398;

	typedef struct packed {
		logic [63:0] entry_time_ns;
		logic [63:0] exit_time_ns;
	} in_t;

	typedef struct packed {
		logic [44:0] real_ms;
		logic [63:0] deliv_ms;
		logic [44:0] lost_ms;
		logic [6:0]  lost_percent;
		logic [54:0] avg_handler_us;
		logic [54:0] max_handler_us;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPENT,
		ST_UPDATE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_LOST,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_REAL,
		OP_DMS,
		OP_PCT,
		OP_AVG1,
		OP_AVG2,
		OP_MAX
	} div_op_t;

	typedef struct packed {
		logic    load_in;
		logic    step_spent;
		logic    step_update;
		logic    div_start;
		logic    div_capture;
		div_op_t div_op;
		logic    calc_lost;
		logic    finish;
	} cmd_t;

	typedef struct packed {
		logic timed;
		logic report_due;
		logic div_idle;
		logic out_free;
	} status_t;

	// x * 1000 modulo 2^64, as 1024x - 16x - 8x
	function automatic logic [63:0] mul1000(input logic [63:0] x);
		mul1000 = (x << 10) - (x << 4) - (x << 3);
	endfunction

	// x * 100 as 64x + 32x + 4x
	function automatic logic [63:0] mul100(input logic [44:0] x);
		logic [63:0] w;
		w = {19'd0, x};
		mul100 = (w << 6) + (w << 5) + (w << 2);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tdm_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tdm_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic      [63:0] quotient,
	output logic             idle
);

	logic [6:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dsr_q;
	logic [64:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[63]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != 7'd0) begin
			rem_q <= fits ? 64'(trial - {1'b0, dsr_q}) : trial[63:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign quotient = quo_q;
	assign idle     = cnt_q == 7'd0;

endmodule

`default_nettype wire

// ===== rtl/tdm_dp.sv =====
`default_nettype none

module tdm_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [19:0]           cfg_data,
	input  wire tdm_pkg::in_t          in_data,
	input  wire logic                  out_stall,
	output logic                       out_valid,
	output tdm_pkg::out_t              out_data,
	input  wire tdm_pkg::cmd_t         cmd,
	output tdm_pkg::status_t           status
);

	logic [19:0] rate_q;
	logic [15:0] period_q;

	logic [63:0] entry_q;
	logic [63:0] exit_q;
	logic [63:0] spent_q;

	logic [63:0] tick_q;
	logic [63:0] ws_ns_q;
	logic [63:0] ws_tick_q;
	logic [63:0] total_q;
	logic [63:0] max_q;

	logic [63:0] elapsed_q;
	logic [63:0] delivered_q;
	logic [44:0] real_q;
	logic [63:0] dms_q;
	logic [44:0] lost_q;
	logic [6:0]  pct_q;
	logic [63:0] avg1_q;
	logic [54:0] avg_q;
	logic [54:0] maxus_q;

	tdm_pkg::out_t out_q;
	logic          out_valid_q;

	logic [63:0] delivered_now;
	logic [63:0] div_a;
	logic [63:0] div_b;
	logic [63:0] div_quo;
	logic [63:0] var_quo;
	logic        var_idle;

	// Constant divide unit: reciprocal multiply in four 32 x 32 partial products
	logic         cdiv_op;
	logic         cdiv_ms;
	logic [2:0]   cdiv_cnt_q;
	logic [63:0]  cdiv_y_q;
	logic [63:0]  cdiv_m_q;
	logic [127:0] cdiv_acc_q;
	logic [63:0]  pp_a;
	logic [63:0]  pp_b;
	logic [63:0]  pp;
	logic [127:0] pp_shifted;
	logic [63:0]  cdiv_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= tdm_pkg::TickRateReset;
			period_q <= tdm_pkg::ReportPeriodReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdm_pkg::CfgTickRateHz:   rate_q   <= cfg_data;
				tdm_pkg::CfgReportPeriod: period_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			entry_q <= in_data.entry_time_ns;
			exit_q  <= in_data.exit_time_ns;
		end
		if (cmd.step_spent) begin
			spent_q <= (exit_q > entry_q) ? exit_q - entry_q : '0;
		end
		if (cmd.step_update) begin
			elapsed_q   <= exit_q - ws_ns_q;
			delivered_q <= delivered_now;
		end
	end

	assign delivered_now = tick_q - ws_tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			ws_ns_q   <= '0;
			ws_tick_q <= '0;
			total_q   <= '0;
			max_q     <= '0;
		end else if (cmd.step_spent) begin
			tick_q <= tick_q + 64'd1;
		end else if (cmd.step_update) begin
			total_q <= total_q + spent_q;
			if (spent_q > max_q) begin
				max_q <= spent_q;
			end
			if (ws_ns_q == 64'd0) begin
				ws_ns_q   <= entry_q;
				ws_tick_q <= tick_q;
			end
		end else if (cmd.finish) begin
			ws_ns_q   <= exit_q;
			ws_tick_q <= tick_q;
			total_q   <= '0;
			max_q     <= '0;
		end
	end

	always_comb begin
		cdiv_op = 1'b0;
		cdiv_ms = 1'b0;
		unique case (cmd.div_op)
			tdm_pkg::OP_REAL: begin
				div_a   = elapsed_q;
				div_b   = '0;
				cdiv_op = 1'b1;
				cdiv_ms = 1'b1;
			end
			tdm_pkg::OP_DMS: begin
				div_a = tdm_pkg::mul1000(delivered_q);
				div_b = {44'd0, rate_q};
			end
			tdm_pkg::OP_PCT: begin
				div_a = tdm_pkg::mul100(lost_q);
				div_b = {19'd0, real_q};
			end
			tdm_pkg::OP_AVG1: begin
				div_a = total_q;
				div_b = delivered_q;
			end
			tdm_pkg::OP_AVG2: begin
				div_a   = avg1_q;
				div_b   = '0;
				cdiv_op = 1'b1;
			end
			tdm_pkg::OP_MAX: begin
				div_a   = max_q;
				div_b   = '0;
				cdiv_op = 1'b1;
			end
			default: begin
				div_a = '0;
				div_b = '0;
			end
		endcase
	end

	// Variable divisors go to the restoring divider
	tdm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start && !cdiv_op),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (var_quo),
		.idle     (var_idle)
	);

	// Divide by 1000 or 1000000: pre-shift, then accumulate one partial product a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cdiv_cnt_q <= '0;
		end else if (cmd.div_start && cdiv_op) begin
			cdiv_cnt_q <= 3'd4;
		end else if (cdiv_cnt_q != 3'd0) begin
			cdiv_cnt_q <= cdiv_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start && cdiv_op) begin
			cdiv_y_q   <= cdiv_ms ? (div_a >> 6) : (div_a >> 3);
			cdiv_m_q   <= cdiv_ms ? tdm_pkg::RecipMs : tdm_pkg::RecipUs;
			cdiv_acc_q <= '0;
		end else if (cdiv_cnt_q != 3'd0) begin
			cdiv_acc_q <= cdiv_acc_q + pp_shifted;
		end
	end

	// low x low, low x high, high x low, then high x high
	always_comb begin
		pp_a = {32'd0, cdiv_y_q[31:0]};
		pp_b = {32'd0, cdiv_m_q[31:0]};
		case (cdiv_cnt_q)
			3'd3: pp_b = {32'd0, cdiv_m_q[63:32]};
			3'd2: pp_a = {32'd0, cdiv_y_q[63:32]};
			3'd1: begin
				pp_a = {32'd0, cdiv_y_q[63:32]};
				pp_b = {32'd0, cdiv_m_q[63:32]};
			end
			default: ;
		endcase
	end

	assign pp = pp_a * pp_b;

	always_comb begin
		case (cdiv_cnt_q)
			3'd4:       pp_shifted = {64'd0, pp};
			3'd3, 3'd2: pp_shifted = {32'd0, pp, 32'd0};
			3'd1:       pp_shifted = {pp, 64'd0};
			default:    pp_shifted = '0;
		endcase
	end

	assign cdiv_quo = cdiv_ms ? {13'd0, cdiv_acc_q[127:77]} : {4'd0, cdiv_acc_q[127:68]};

	assign div_quo  = cdiv_op ? cdiv_quo : var_quo;

	// Results of the report; zero divisors are replaced by the defined values
	always_ff @(posedge clk) begin
		if (cmd.div_capture) begin
			unique case (cmd.div_op)
				tdm_pkg::OP_REAL: real_q <= div_quo[44:0];
				tdm_pkg::OP_DMS:  dms_q  <= (rate_q != 20'd0) ? div_quo : delivered_q;
				tdm_pkg::OP_PCT:  pct_q  <= (real_q != 45'd0) ? div_quo[6:0] : 7'd0;
				tdm_pkg::OP_AVG1: avg1_q <= div_quo;
				tdm_pkg::OP_AVG2: avg_q  <= (delivered_q != 64'd0) ? div_quo[54:0] : 55'd0;
				tdm_pkg::OP_MAX:  maxus_q <= div_quo[54:0];
				default: ;
			endcase
		end
		if (cmd.calc_lost) begin
			lost_q <= ({19'd0, real_q} > dms_q) ? real_q - dms_q[44:0] : '0;
		end
		if (cmd.finish) begin
			out_q.real_ms        <= real_q;
			out_q.deliv_ms       <= dms_q;
			out_q.lost_ms        <= lost_q;
			out_q.lost_percent   <= pct_q;
			out_q.avg_handler_us <= avg_q;
			out_q.max_handler_us <= maxus_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.timed      = entry_q != 64'd0;
	assign status.report_due = (ws_ns_q != 64'd0) && (delivered_now >= {48'd0, period_q});
	assign status.div_idle   = var_idle && (cdiv_cnt_q == 3'd0);
	assign status.out_free   = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

// ===== rtl/tdm_ctrl.sv =====
`default_nettype none

module tdm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire tdm_pkg::status_t  status,
	output tdm_pkg::cmd_t          cmd
);

	tdm_pkg::state_t  state_q, state_n;
	tdm_pkg::div_op_t op_q, op_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdm_pkg::ST_IDLE;
			op_q    <= tdm_pkg::OP_REAL;
		end else begin
			state_q <= state_n;
			op_q    <= op_n;
		end
	end

	always_comb begin
		state_n         = state_q;
		op_n            = op_q;
		in_stall        = 1'b1;
		cmd             = '0;
		cmd.div_op      = op_q;
		unique case (state_q)
			tdm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_n     = tdm_pkg::ST_SPENT;
				end
			end
			tdm_pkg::ST_SPENT: begin
				cmd.step_spent = 1'b1;
				state_n = status.timed ? tdm_pkg::ST_UPDATE : tdm_pkg::ST_IDLE;
			end
			tdm_pkg::ST_UPDATE: begin
				cmd.step_update = 1'b1;
				if (status.report_due) begin
					op_n    = tdm_pkg::OP_REAL;
					state_n = tdm_pkg::ST_DIV_GO;
				end else begin
					state_n = tdm_pkg::ST_IDLE;
				end
			end
			tdm_pkg::ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_n       = tdm_pkg::ST_DIV_WAIT;
			end
			tdm_pkg::ST_DIV_WAIT: begin
				if (status.div_idle) begin
					cmd.div_capture = 1'b1;
					state_n         = tdm_pkg::ST_DIV_GO;
					unique case (op_q)
						tdm_pkg::OP_REAL: op_n = tdm_pkg::OP_DMS;
						tdm_pkg::OP_DMS:  state_n = tdm_pkg::ST_LOST;
						tdm_pkg::OP_PCT:  op_n = tdm_pkg::OP_AVG1;
						tdm_pkg::OP_AVG1: op_n = tdm_pkg::OP_AVG2;
						tdm_pkg::OP_AVG2: op_n = tdm_pkg::OP_MAX;
						tdm_pkg::OP_MAX:  state_n = tdm_pkg::ST_FINISH;
						default:          state_n = tdm_pkg::ST_FINISH;
					endcase
				end
			end
			tdm_pkg::ST_LOST: begin
				cmd.calc_lost = 1'b1;
				op_n          = tdm_pkg::OP_PCT;
				state_n       = tdm_pkg::ST_DIV_GO;
			end
			tdm_pkg::ST_FINISH: begin
				// hold until the output register can take the report
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_n    = tdm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = tdm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/tick_delivery_monitor.sv =====
`default_nettype none

// Timer tick delivery monitor. Each input transfer is one delivered tick with
// its handler entry and exit timestamps in ns; an entry of zero means there is
// no timestamp source and only the tick count advances. Timed ticks add their
// handler time (zero when exit is not after entry) to a window total and track
// the maximum; the first timed tick opens the window. When report_period_ticks
// ticks have passed since the window opened, one output transfer carries the
// real, delivered and lost milliseconds, the lost percentage and the average
// and maximum handler microseconds, and a new window opens at the exit time.
// An untimed tick passes through the load and spent steps, and a timed tick
// without report also through the update step, after which in_stall drops
// again. A tick that causes a report adds three 64-bit divides by a variable
// on a restoring divider and three divides by 1000 or 1000000 done as a
// reciprocal multiply in four 32-bit partial products, plus a step for the
// lost time. A finished report sits in the output register, so the next
// tick is taken while the report waits; a second report waits only if the
// first is unread. Configuration (index 0 tick_rate_hz, index 1
// report_period_ticks, others ignored) is to be written by the user only
// while no tick is in progress; the block itself does not enforce this.
module tick_delivery_monitor (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [19:0]   cfg_data,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire tdm_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output tdm_pkg::out_t      out_data
);

	tdm_pkg::cmd_t    cmd;
	tdm_pkg::status_t status;

	// Sequence each tick and each report step
	tdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Hold window state, divide and register the report
	tdm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

	// A new report appears only after the finish step of a report
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.finish))
		else $error("report appeared without a finish step");

	// No tick is taken while the divider is still running
	a_accept_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> status.div_idle)
		else $error("tick accepted during a divide");

	// Lost time never exceeds real time, and the percentage stays in range
	a_lost_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.lost_ms <= out_data.real_ms)
			&& (out_data.lost_percent <= 7'd100))
		else $error("lost time out of range");

	// A finish step never overwrites a report that is still unread
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid || !out_stall))
		else $error("report overwritten");

endmodule

`default_nettype wire

// ===== verif/tick_report_checker.sv =====
`timescale 1ns / 100ps

module tick_report_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [19:0]   cfg_data,
	input  logic          in_valid,
	input  logic          in_stall,
	input  tdm_pkg::in_t  in_data,
	input  logic          out_valid,
	input  logic          out_stall,
	input  tdm_pkg::out_t out_data,
	output int            error_count,
	output int            reports_pending,
	output int            ticks_seen,
	output int            timed_ticks,
	output int            reports_seen
);

	localparam int PrintLimit = 40;

	logic [19:0]   rate_hz;
	logic [15:0]   period_ticks;
	logic [63:0]   ticks_total;
	logic [63:0]   win_start_ns;
	logic [63:0]   win_start_tick;
	logic [63:0]   spent_total_ns;
	logic [63:0]   spent_max_ns;
	tdm_pkg::out_t expected_reports[$];

	task automatic account_tick(input tdm_pkg::in_t t);
		logic [63:0]   spent, delivered, elapsed, real_ms, dms, lost, pct, avg, longest;
		tdm_pkg::out_t rpt;
		ticks_total = ticks_total + 64'd1;
		if (t.entry_time_ns == 64'd0)
			return;
		spent = (t.exit_time_ns > t.entry_time_ns) ? t.exit_time_ns - t.entry_time_ns : 64'd0;
		spent_total_ns = spent_total_ns + spent;
		if (spent > spent_max_ns)
			spent_max_ns = spent;
		// first timed tick opens the window
		if (win_start_ns == 64'd0) begin
			win_start_ns = t.entry_time_ns;
			win_start_tick = ticks_total;
			return;
		end
		delivered = ticks_total - win_start_tick;
		if (delivered < {48'd0, period_ticks})
			return;
		elapsed = t.exit_time_ns - win_start_ns;
		real_ms = elapsed / tdm_pkg::NsPerMs;
		dms = (rate_hz != 20'd0) ? (delivered * tdm_pkg::NsPerUs) / {44'd0, rate_hz}
			: delivered;
		lost = (real_ms > dms) ? real_ms - dms : 64'd0;
		pct = (real_ms != 64'd0) ? (lost * 64'd100) / real_ms : 64'd0;
		avg = (delivered != 64'd0) ? (spent_total_ns / delivered) / tdm_pkg::NsPerUs : 64'd0;
		longest = spent_max_ns / tdm_pkg::NsPerUs;
		rpt.real_ms = real_ms[44:0];
		rpt.deliv_ms = dms;
		rpt.lost_ms = lost[44:0];
		rpt.lost_percent = pct[6:0];
		rpt.avg_handler_us = avg[54:0];
		rpt.max_handler_us = longest[54:0];
		expected_reports.push_back(rpt);
		// new window opens at the report time
		win_start_ns = t.exit_time_ns;
		win_start_tick = ticks_total;
		spent_total_ns = 64'd0;
		spent_max_ns = 64'd0;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= PrintLimit)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_hz = tdm_pkg::TickRateReset;
			period_ticks = tdm_pkg::ReportPeriodReset;
			ticks_total = '0;
			win_start_ns = '0;
			win_start_tick = '0;
			spent_total_ns = '0;
			spent_max_ns = '0;
			expected_reports.delete();
			error_count = 0;
			ticks_seen = 0;
			timed_ticks = 0;
			reports_seen = 0;
			reports_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tdm_pkg::CfgTickRateHz:   rate_hz = cfg_data;
					tdm_pkg::CfgReportPeriod: period_ticks = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				ticks_seen++;
				if (in_data.entry_time_ns != 64'd0)
					timed_ticks++;
				account_tick(in_data);
			end
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					error_count++;
					if (error_count <= PrintLimit)
						$display("%0t: report transfer with none expected, got %h",
							$time, out_data);
				end else begin
					tdm_pkg::out_t want;
					want = expected_reports.pop_front();
					reports_seen++;
					check_field("real_ms", want.real_ms, out_data.real_ms);
					check_field("deliv_ms", want.deliv_ms, out_data.deliv_ms);
					check_field("lost_ms", want.lost_ms, out_data.lost_ms);
					check_field("lost_percent", want.lost_percent, out_data.lost_percent);
					check_field("avg_handler_us", want.avg_handler_us, out_data.avg_handler_us);
					check_field("max_handler_us", want.max_handler_us, out_data.max_handler_us);
				end
			end
			reports_pending = expected_reports.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int HalfPeriod  = 4;
	localparam int SettleTicks = 16;   // enough for an untimed or plain timed tick to finish
	localparam int ReportSpan  = 450;
	localparam int RandomTicks = 1800;

	typedef enum int {STALL_NONE, STALL_SCATTER, STALL_RUNS} stall_mode_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [1:0]    cfg_index = '0;
	logic [19:0]   cfg_data = '0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	tdm_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	tdm_pkg::out_t out_data;

	int error_count, reports_pending, ticks_seen, timed_ticks, reports_seen;

	// stimulus state
	int          burst_left = 0;
	int          settings_applied = 0;
	logic [63:0] clock_ns = 64'd5_000_000_000;

	// receiver state
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left = 0;
	int          run_left = 0;

	always #(HalfPeriod) clk = ~clk;

	tick_delivery_monitor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	tick_report_checker report_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.error_count     (error_count),
		.reports_pending (reports_pending),
		.ticks_seen      (ticks_seen),
		.timed_ticks     (timed_ticks),
		.reports_seen    (reports_seen)
	);

	// Receiver: switch between no stalls, scattered stalls and long stall runs
	// at random intervals so that reports wait on every phase.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			mode_left = $urandom_range(50, 400);
		end else
			mode_left--;
		case (stall_mode)
			STALL_NONE:    out_stall <= 1'b0;
			STALL_SCATTER: out_stall <= ($urandom_range(0, 2) == 0);
			default: begin
				if (run_left == 0) begin
					out_stall <= ~out_stall;
					run_left = $urandom_range(1, 40);
				end else
					run_left--;
			end
		endcase
	end

	// Present one tick and hold it until the transfer. Between bursts drop valid
	// for a random gap; the gap is never zero so valid is not lowered and raised
	// in the same step.
	task automatic send_tick(input logic [63:0] enter_ns, input logic [63:0] exit_ns);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		in_data <= {enter_ns, exit_ns};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
	endtask

	// Drop valid right after the last transfer of a phase.
	task automatic release_input();
		in_valid <= 1'b0;
		burst_left = 0;
	endtask

	// Wait until every expected report has been taken, then wait long enough for
	// the block to finish any tick that causes no report.
	task automatic settle();
		do
			@(negedge clk);
		while (reports_pending != 0);
		repeat (SettleTicks) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [19:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly a steady tick stream at the nominal rate with handler time and the
	// odd lost stretch; the rest is untimed ticks, exits before entry, noise, clock
	// jumps backwards and exits at time zero.
	task automatic drive_random_tick(input logic [19:0] rate);
		logic [63:0] nominal, enter_ns, exit_ns;
		int          pick;
		nominal = (rate != 20'd0) ? 64'd1_000_000_000 / {44'd0, rate} : 64'd1_000_000;
		clock_ns = clock_ns + nominal + $urandom_range(0, nominal[31:0] / 4);
		if ($urandom_range(0, 9) == 0)
			clock_ns = clock_ns + nominal * $urandom_range(2, 20);
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			enter_ns = clock_ns;
			exit_ns = clock_ns + $urandom_range(0, 300_000);
		end else if (pick < 70) begin
			enter_ns = 64'd0;
			exit_ns = {$urandom, $urandom};
		end else if (pick < 78) begin
			enter_ns = clock_ns;
			exit_ns = clock_ns - $urandom_range(1, 5000);
		end else if (pick < 86) begin
			enter_ns = {$urandom, $urandom};
			exit_ns = {$urandom, $urandom};
		end else if (pick < 92) begin
			clock_ns = clock_ns - $urandom_range(1, 50_000_000);
			enter_ns = clock_ns;
			exit_ns = clock_ns + $urandom_range(0, 1000);
		end else begin
			enter_ns = clock_ns;
			exit_ns = 64'd0;
		end
		send_tick(enter_ns, exit_ns);
	endtask

	initial begin
		int          random_sent, phase_items, period_pick, wait_cycles;
		logic [19:0] rate;
		logic [15:0] period;

		random_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: untimed tick, window opened by an all-ones entry with
		// exit before entry, then a tick with an enormous handler time.
		send_tick(64'd0, '1);
		send_tick('1, 64'd0);
		send_tick(64'd1, '1);
		release_input();
		settle();

		// Rate zero counts ticks as milliseconds; period zero reports on every
		// timed tick after the window opens.
		write_reg(tdm_pkg::CfgTickRateHz, 20'd0);
		write_reg(tdm_pkg::CfgReportPeriod, 20'd0);
		settings_applied++;
		send_tick(64'd5, 64'd3_000_000);           // elapsed wraps past the all-ones start
		send_tick(64'd0, 64'd0);
		send_tick(64'd10_000_000, 64'd12_000_000);
		send_tick(64'd20_000_000, 64'd0);          // report at time zero closes the window
		send_tick(64'd30_000_000, 64'd30_500_000); // reopen
		send_tick(64'd31_000_000, 64'd31_000_000);
		release_input();
		settle();

		// Top rate, period one, and writes to unused indexes that must be ignored.
		write_reg(tdm_pkg::CfgTickRateHz, 20'd1_000_000);
		write_reg(tdm_pkg::CfgReportPeriod, 20'd1);
		write_reg(2'd2, 20'hAAAAA);
		write_reg(2'd3, 20'h55555);
		settings_applied++;
		send_tick(64'd40_000_000, 64'd40_001_000);
		send_tick(64'd41_000_000, 64'd41_999_999);
		send_tick(64'h8000_0000_0000_0000, 64'h8000_0000_0001_0000);
		release_input();
		settle();

		// Rate beyond the nominal range; period with junk in the upper data bits.
		write_reg(tdm_pkg::CfgTickRateHz, 20'hFFFFF);
		write_reg(tdm_pkg::CfgReportPeriod, 20'hF0002);
		settings_applied++;
		send_tick(64'd50_000_000, 64'd50_005_000);
		send_tick(64'd0, 64'hFFFF_0000_FFFF_0000);
		send_tick(64'd52_000_000, 64'd52_000_007);
		send_tick(64'd53_000_000, 64'd53_000_100);
		release_input();
		settle();

		// Longest period: the window never closes in this short stretch.
		write_reg(tdm_pkg::CfgTickRateHz, 20'd1000);
		write_reg(tdm_pkg::CfgReportPeriod, 20'hFFFF);
		settings_applied++;
		repeat (30) drive_random_tick(20'd1000);
		random_sent += 30;
		release_input();

		// Random phases, each at its own setting; the settle before each write
		// also holds the sender until every report has arrived.
		while (random_sent < RandomTicks) begin
			settle();
			case ($urandom_range(0, 7))
				0: rate = 20'd0;
				1: rate = 20'd1;
				2: rate = 20'd200;
				3: rate = 20'd1000;
				4: rate = 20'd1_000_000;
				5: rate = 20'hFFFFF;
				6: rate = 20'd60;
				default: rate = 20'($urandom_range(2, 1_000_000));
			endcase
			period_pick = $urandom_range(0, 9);
			if (period_pick < 6)
				period = 16'($urandom_range(0, 4));
			else if (period_pick < 9)
				period = 16'($urandom_range(5, 16));
			else
				period = 16'($urandom_range(17, 60));
			write_reg(tdm_pkg::CfgTickRateHz, rate);
			write_reg(tdm_pkg::CfgReportPeriod, {4'd0, period});
			settings_applied++;
			phase_items = $urandom_range(60, 200);
			repeat (phase_items) drive_random_tick(rate);
			random_sent += phase_items;
			release_input();
		end

		// Drain: wait for outstanding reports with a bound, then watch a report's
		// worth of cycles for anything unexpected.
		wait_cycles = 0;
		while (reports_pending != 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (ReportSpan) @(posedge clk);

		if (reports_pending != 0)
			$display("%0t: %0d expected reports never arrived", $time, reports_pending);
		$display("Covered %0d tick transfers (%0d timed) and %0d reports over %0d settings,",
			ticks_seen, timed_ticks, reports_seen, settings_applied);
		$display("with rates from zero to the 20-bit maximum and periods from 0 to 65535.");
		if (error_count == 0 && reports_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tdm_pkg.sv
rtl/tdm_div.sv
rtl/tdm_dp.sv
rtl/tdm_ctrl.sv
rtl/tick_delivery_monitor.sv
verif/tick_report_checker.sv
verif/testbench.sv
